FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Types and constants for the position repetition stack.
// ----------------------------------------------------------------------------
package prs_pkg;

    // Sizes
    localparam int unsigned STACK_DEPTH_DEF = 1024;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned CNT_W           = 10;
    localparam int unsigned SEEN_W          = 10;
    localparam int unsigned DEPTH_OUT_W     = 11;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 10;

    // Constants
    localparam logic [CNT_W-1:0]  COUNT_MAX          = 10'd1023;
    localparam logic [SEEN_W-1:0] THREEFOLD_TARGET   = 10'd3;
    localparam logic [CNT_W-1:0]  REPEAT_TARGET_RST  = 10'd3;
    localparam logic [CNT_W-1:0]  DRAW_HALFMOVES_RST = 10'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TARGET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_HALFMOVES = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_LAST   = 2'd2,
        ERR_NOINIT = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POPTOP,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] position_key;
        logic             irreversible;
    } in_item_t;

    typedef struct packed {
        logic                   draw;
        logic                   fifty_move;
        logic                   threefold;
        logic                   repeated;
        logic [CNT_W-1:0]       halfmove_count;
        logic [DEPTH_OUT_W-1:0] stack_depth;
        logic [1:0]             error_code;
    } out_item_t;

    // One stack entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

FILE: design/prs_if.sv
// ----------------------------------------------------------------------------
// prs_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface prs_in_if
    import prs_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prs_out_if
    import prs_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/prs_ram.sv
// ----------------------------------------------------------------------------
// prs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/position_repetition_stack.sv
// ----------------------------------------------------------------------------
// position_repetition_stack
// Stack of position keys with half-move counts; reports repetition and
// fifty-move status of the top entry after every command.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------
//  req      | in  | valid/ready   | command, position_key, irreversible
//  rsp      | out | valid/ready   | draw .. error_code (one per command)
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_wr_data
//
//  For each command, W entries are read back from the stack RAM, one per
//  cycle (at most halfmove_count + 1); a pop that succeeds first reads the
//  new top entry.
//  The walk stops at the first entry whose count does not decrease, at the
//  bottom of the stack, or once both repetition targets are met.
//  Reset sets pointer, state, valid and config regs; RAM is never cleared.
//  A new command is taken while the previous result waits in the output
//  register; a stalled output holds the block in its final cycle.
// ----------------------------------------------------------------------------
module position_repetition_stack
    import prs_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    prs_in_if.sink                req,
    prs_out_if.source             rsp
);

`include "assert_macros.svh"

    localparam int unsigned PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    // Control state
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             rsp_valid_reg;
    logic [CNT_W-1:0] repeat_target_reg;
    logic [CNT_W-1:0] draw_halfmoves_reg;

    // Payload state
    logic [KEY_W-1:0]  top_key_reg, top_key_next;
    logic [CNT_W-1:0]  top_cnt_reg, top_cnt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  last_reg, last_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    err_t              err_reg, err_next;
    out_item_t         rsp_data_reg, rsp_data_next;

    // RAM port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    entry_t            rd_entry;

    // Misc
    logic              req_ready;
    logic              req_fire;
    logic              pop_ok;
    logic              out_load;
    logic [CNT_W-1:0]  push_cnt;
    logic              walk_stop;
    logic              walk_match;
    logic [SEEN_W-1:0] seen_walk;
    logic              walk_more;

    // Stack RAM: key and count side by side
    prs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    assign req_fire = req.valid && req_ready;

    // Count of a pushed entry: zero if irreversible, else top count plus one, saturating
    assign push_cnt = req.data.irreversible ? '0 :
                      (top_cnt_reg == COUNT_MAX) ? COUNT_MAX : top_cnt_reg + CNT_W'(1);

    // One step of the backward walk
    assign walk_stop  = rd_entry.count >= last_reg;
    assign walk_match = !walk_stop && (rd_entry.key == top_key_reg);
    assign seen_walk  = seen_reg + SEEN_W'(walk_match);
    assign walk_more  = !walk_stop && (idx_reg != '0) &&
                        !((seen_walk >= THREEFOLD_TARGET) && (seen_walk >= repeat_target_reg));

    // Result of the top entry
    always_comb
    begin
        rsp_data_next             = '0;
        rsp_data_next.stack_depth = DEPTH_OUT_W'(ptr_reg);
        rsp_data_next.error_code  = err_reg;
        if (ptr_reg != '0)
        begin
            rsp_data_next.halfmove_count = top_cnt_reg;
            rsp_data_next.fifty_move     = top_cnt_reg >= draw_halfmoves_reg;
            rsp_data_next.threefold      = seen_reg >= THREEFOLD_TARGET;
            rsp_data_next.repeated       = seen_reg >= repeat_target_reg;
            rsp_data_next.draw           = rsp_data_next.fifty_move || rsp_data_next.threefold;
        end
    end

    // Sequencer: next state and RAM control
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        top_key_next = top_key_reg;
        top_cnt_next = top_cnt_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        err_next     = err_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        pop_ok       = 1'b0;
        out_load     = 1'b0;
        req_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    err_next = ERR_OK;
                    unique case (cmd_t'(req.data.command))
                        CMD_INIT:
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = '0;
                            mem_wdata.key   = req.data.position_key;
                            mem_wdata.count = '0;
                            ptr_next        = PTR_W'(1);
                            top_key_next    = req.data.position_key;
                            top_cnt_next    = '0;
                        end
                        CMD_PUSH:
                        begin
                            if (ptr_reg == '0)
                            begin
                                err_next = ERR_NOINIT;
                            end
                            else if (ptr_reg >= PTR_W'(STACK_DEPTH))
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = ADDR_W'(ptr_reg);
                                mem_wdata.key   = req.data.position_key;
                                mem_wdata.count = push_cnt;
                                ptr_next        = ptr_reg + PTR_W'(1);
                                top_key_next    = req.data.position_key;
                                top_cnt_next    = push_cnt;
                            end
                        end
                        CMD_POP:
                        begin
                            if (ptr_reg == '0)
                            begin
                                err_next = ERR_NOINIT;
                            end
                            else if (ptr_reg == PTR_W'(1))
                            begin
                                err_next = ERR_LAST;
                            end
                            else
                            begin
                                ptr_next = ptr_reg - PTR_W'(1);
                                pop_ok   = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    seen_next = SEEN_W'(1);
                    if (pop_ok)
                    begin
                        // fetch the new top entry
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(ptr_reg - PTR_W'(2));
                        state_next = ST_POPTOP;
                    end
                    else if (ptr_next >= PTR_W'(2))
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(ptr_next - PTR_W'(2));
                        idx_next   = ADDR_W'(ptr_next - PTR_W'(2));
                        last_next  = top_cnt_next;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_POPTOP:
            begin
                top_key_next = rd_entry.key;
                top_cnt_next = rd_entry.count;
                if (ptr_reg >= PTR_W'(2))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(ptr_reg - PTR_W'(2));
                    idx_next   = ADDR_W'(ptr_reg - PTR_W'(2));
                    last_next  = rd_entry.count;
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                seen_next = seen_walk;
                if (walk_more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg - ADDR_W'(1);
                    idx_next   = idx_reg - ADDR_W'(1);
                    last_next  = rd_entry.count;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_target_reg  <= REPEAT_TARGET_RST;
            draw_halfmoves_reg <= DRAW_HALFMOVES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_REPEAT_TARGET:  repeat_target_reg  <= cfg_wr_data;
                CFG_DRAW_HALFMOVES: draw_halfmoves_reg <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_key_reg <= top_key_next;
        top_cnt_reg <= top_cnt_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        seen_reg    <= seen_next;
        err_reg     <= err_next;
        if (out_load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Checks
    `ASSERT_NEVER(a_ptr_range, ptr_reg > PTR_W'(STACK_DEPTH), "stack pointer beyond depth")
    `ASSERT_CLK(a_init_ptr, req_fire && (req.data.command == CMD_INIT) |=> ptr_reg == PTR_W'(1), "init did not leave one entry")
    `ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE), "result raised outside final cycle")
    `ASSERT_CLK(a_walk_ctx, (state_reg == ST_WALK) |-> (seen_reg != '0) && (ptr_reg >= PTR_W'(2)), "walk with empty run or short stack")

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for position_repetition_stack. Commands go in over the
// req channel with bursty timing and results are pulled from rsp under a
// changing stall pattern. A scoreboard keeps its own stack of keys and
// half-move counts, predicts every result and checks it field by field.
// The run covers directed corner cases, a fill to the full stack, and random
// game-like sequences under several register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prs_pkg::*;

    localparam int unsigned        IDLE_LIMIT    = 5000;
    localparam int unsigned        HOLD_CYCLES   = 400;
    localparam int unsigned        SETTLE_CYCLES = 1100;
    localparam int unsigned        PHASE_ITEMS   = 150;
    localparam logic [1:0]         CMD_RESERVED  = 2'd3;
    localparam logic [KEY_W-1:0]   KEY_ZERO      = '0;
    localparam logic [KEY_W-1:0]   KEY_ONES      = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow stack, expected result queue and checking
    // ------------------------------------------------------------------------
    class repetition_scoreboard;
        bit [KEY_W-1:0]  key_mem   [STACK_DEPTH_DEF];
        bit [CNT_W-1:0]  count_mem [STACK_DEPTH_DEF];
        int unsigned     depth;
        bit [CNT_W-1:0]  repeat_target;
        bit [CNT_W-1:0]  draw_halfmoves;
        out_item_t       expected_q [$];
        int unsigned     mismatches;

        function new();
            depth          = 0;
            repeat_target  = REPEAT_TARGET_RST;
            draw_halfmoves = DRAW_HALFMOVES_RST;
            mismatches     = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_REPEAT_TARGET)
                repeat_target = value;
            else
                draw_halfmoves = value;
        endfunction

        // Walk down from the top while counts strictly fall; count top-key hits
        function bit key_occurrences_reach(int unsigned target);
            int unsigned    seen;
            int unsigned    idx;
            bit [KEY_W-1:0] top_key;
            bit [CNT_W-1:0] last;
            seen    = 1;
            idx     = depth - 1;
            top_key = key_mem[idx];
            last    = count_mem[idx];
            while (idx > 0 && seen < target)
            begin
                idx--;
                if (count_mem[idx] >= last)
                    break;
                last = count_mem[idx];
                if (key_mem[idx] == top_key)
                    seen++;
            end
            return seen >= target;
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void note_command(in_item_t item);
            out_item_t      r;
            bit [CNT_W-1:0] prev;
            r            = '0;
            r.error_code = ERR_OK;
            case (item.command)
                CMD_INIT:
                begin
                    key_mem[0]   = item.position_key;
                    count_mem[0] = '0;
                    depth        = 1;
                end
                CMD_PUSH:
                begin
                    if (depth == 0)
                        r.error_code = ERR_NOINIT;
                    else if (depth >= STACK_DEPTH_DEF)
                        r.error_code = ERR_FULL;
                    else
                    begin
                        prev             = count_mem[depth-1];
                        key_mem[depth]   = item.position_key;
                        count_mem[depth] = item.irreversible ? '0 :
                                           (prev == COUNT_MAX) ? COUNT_MAX : prev + 1'b1;
                        depth++;
                    end
                end
                CMD_POP:
                begin
                    if (depth == 0)
                        r.error_code = ERR_NOINIT;
                    else if (depth == 1)
                        r.error_code = ERR_LAST;
                    else
                        depth--;
                end
                default: ;  // reserved code: no change
            endcase
            if (depth > 0)
            begin
                r.halfmove_count = count_mem[depth-1];
                r.fifty_move     = (count_mem[depth-1] >= draw_halfmoves);
                r.threefold      = key_occurrences_reach(THREEFOLD_TARGET);
                r.repeated       = key_occurrences_reach(repeat_target);
                r.draw           = r.fifty_move | r.threefold;
            end
            r.stack_depth = depth[DEPTH_OUT_W-1:0];
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            mismatches++;
            $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.draw !== want.draw)
                report_mismatch("draw", got.draw, want.draw);
            if (got.fifty_move !== want.fifty_move)
                report_mismatch("fifty_move", got.fifty_move, want.fifty_move);
            if (got.threefold !== want.threefold)
                report_mismatch("threefold", got.threefold, want.threefold);
            if (got.repeated !== want.repeated)
                report_mismatch("repeated", got.repeated, want.repeated);
            if (got.halfmove_count !== want.halfmove_count)
                report_mismatch("halfmove_count", got.halfmove_count, want.halfmove_count);
            if (got.stack_depth !== want.stack_depth)
                report_mismatch("stack_depth", got.stack_depth, want.stack_depth);
            if (got.error_code !== want.error_code)
                report_mismatch("error_code", got.error_code, want.error_code);
        endtask

        task flag_leftovers();
            if (expected_q.size() != 0)
                report_mismatch("results never delivered", 0, expected_q.size());
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    prs_in_if  req_if ();
    prs_out_if rsp_if ();

    position_repetition_stack dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    repetition_scoreboard sb = new();
    int unsigned          burst_left;
    bit                   hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Transfer monitor: check results, then note commands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.data);
            if (req_if.valid && req_if.ready)
                sb.note_command(req_if.data);
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result sink: random stall segments, plus a long hold-off on request
    initial
    begin
        int unsigned seg_left;
        int unsigned stall_pct;
        int unsigned hold_left;
        rsp_if.ready = 1'b0;
        seg_left     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES;
                rsp_if.ready = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 200);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks (called at the falling edge)
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // One command transfer, then either stay in the burst or idle a while
    task automatic issue_command(input logic [1:0] command, input logic [KEY_W-1:0] key,
                                 input logic irreversible);
        in_item_t item;
        item.command      = command;
        item.position_key = key;
        item.irreversible = irreversible;
        req_if.data       = item;
        req_if.valid      = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_for_results();
        req_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_register(idx, value);
    endtask

    // Registers change only with the block drained
    task automatic configure(input logic [CFG_DATA_W-1:0] rep_target,
                             input logic [CFG_DATA_W-1:0] draw_hm);
        wait_for_results();
        write_register(CFG_REPEAT_TARGET, rep_target);
        write_register(CFG_DRAW_HALFMOVES, draw_hm);
    endtask

    // Build up one long reversible line, mostly on a single key, until the stack is full
    task automatic fill_stack();
        logic [KEY_W-1:0] line_key;
        line_key = random_key();
        issue_command(CMD_INIT, line_key, 1'b0);
        for (int i = 1; i < STACK_DEPTH_DEF + 3; i++)
        begin
            if (i == 500)
                hold_req = 1'b1;
            issue_command(CMD_PUSH,
                          ($urandom_range(0, 31) == 0) ? random_key() : line_key, 1'b0);
        end
        repeat ($urandom_range(3, 12))
            issue_command(CMD_POP, random_key(), 1'b0);
        issue_command(CMD_PUSH, line_key, 1'b0);
    endtask

    // Game-like sequences over a small key pool, with some noise mixed in
    task automatic random_phase(input bit with_pressure);
        logic [KEY_W-1:0] pool [3];
        int unsigned      roll;
        foreach (pool[k])
            pool[k] = random_key();
        issue_command(CMD_INIT, pool[0], 1'b0);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (with_pressure && n == 40)
                hold_req = 1'b1;
            if (with_pressure && n == 100)
                wait_for_results();
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                pool[$urandom_range(0, 2)] = random_key();
                issue_command(CMD_INIT, pool[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
            end
            else if (roll < 5)
                issue_command(CMD_RESERVED, random_key(), 1'($urandom_range(0, 1)));
            else if (roll < 65)
                issue_command(CMD_PUSH,
                              ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 2)]
                                                          : random_key(),
                              ($urandom_range(0, 5) == 0));
            else
                issue_command(CMD_POP, random_key(), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        hold_req     = 1'b0;
        burst_left   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, errors before init, repetition, reserved code
        issue_command(CMD_PUSH, KEY_ONES, 1'b1);
        issue_command(CMD_POP, KEY_ZERO, 1'b0);
        issue_command(CMD_RESERVED, KEY_ONES, 1'b1);
        issue_command(CMD_INIT, KEY_ONES, 1'b0);
        issue_command(CMD_POP, KEY_ZERO, 1'b0);
        issue_command(CMD_PUSH, KEY_ZERO, 1'b0);
        issue_command(CMD_PUSH, KEY_ONES, 1'b0);
        issue_command(CMD_PUSH, KEY_ZERO, 1'b0);
        issue_command(CMD_PUSH, KEY_ONES, 1'b0);
        issue_command(CMD_RESERVED, KEY_ZERO, 1'b0);
        issue_command(CMD_POP, KEY_ONES, 1'b1);
        issue_command(CMD_PUSH, KEY_ONES, 1'b1);
        issue_command(CMD_PUSH, KEY_ZERO, 1'b0);
        issue_command(CMD_INIT, 64'h5A5A_A5A5_0F0F_F0F0, 1'b1);

        // Directed: zero targets make repeated and fifty_move always true
        configure('0, '0);
        issue_command(CMD_INIT, random_key(), 1'b0);
        issue_command(CMD_PUSH, random_key(), 1'b0);
        issue_command(CMD_PUSH, random_key(), 1'b1);
        issue_command(CMD_POP, KEY_ZERO, 1'b0);
        issue_command(CMD_POP, KEY_ZERO, 1'b0);
        issue_command(CMD_POP, KEY_ZERO, 1'b0);

        // Full stack, top count reaching its maximum
        configure(10'd2, 10'd1023);
        fill_stack();

        // Random phases over a spread of settings
        configure(10'd1023, 10'd1023);
        random_phase(1'b0);
        configure(10'd1, 10'd1);
        random_phase(1'b0);
        configure(REPEAT_TARGET_RST, DRAW_HALFMOVES_RST);
        random_phase(1'b1);
        configure(10'd4, 10'd8);
        random_phase(1'b0);
        configure(10'd5, 10'd3);
        random_phase(1'b0);

        // Drain and let any stray result show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
